// ===== sv/urma_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range moving average package
// Shared widths, constants and register indexes of the range filter block.
// ----------------------------------------------------------------------------
package urma_pkg;

    // Field widths
    localparam int DUR_W      = 20;   // echo duration in microseconds
    localparam int DIST_W     = 15;   // distance in centimetres
    localparam int WIN_W      = 5;    // window size register
    localparam int SUM_W      = 19;   // running sum of the ring

    // Ring depth and slot index width
    localparam int WINDOW_MAX = 16;
    localparam int SLOT_W     = $clog2(WINDOW_MAX);

    // Duration to centimetres: floor(us * 172 / 10000)
    localparam int CM_SCALE   = 172;
    localparam int CM_DIV     = 10000;
    localparam int PROD_W     = 28;   // 20-bit duration times 8-bit scale

    // The same conversion as (us * CM_RECIP) >> CM_SHIFT, exact for all 20-bit
    // durations. CM_RECIP is ceil(2^32 * 172 / 10000).
    localparam int CM_RECIP   = 73873438;
    localparam int CM_SHIFT   = 32;
    localparam int MUL_W      = 47;   // 20-bit duration times 27-bit reciprocal

    localparam int DVSR_W     = 5;    // divisor register holds a window size

    // Window register reset and clamp values
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(5);
    localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(1);
    localparam logic [WIN_W-1:0] WIN_LIMIT = WIN_W'(WINDOW_MAX);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

endpackage

// ===== sv/urma_echo_if.sv =====
// ----------------------------------------------------------------------------
// Echo duration channel
// Valid/ready channel that carries one measured echo high time per item.
// ----------------------------------------------------------------------------
interface urma_echo_if
    import urma_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] echo_duration_us;

    modport source (output valid, output echo_duration_us, input ready);
    modport sink   (input valid, input echo_duration_us, output ready);
endinterface

// ===== sv/urma_dist_if.sv =====
// ----------------------------------------------------------------------------
// Distance result channel
// Valid/ready channel that carries one distance and proximity flag per item.
// ----------------------------------------------------------------------------
interface urma_dist_if
    import urma_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_cm;
    logic              is_near;

    modport source (output valid, output distance_cm, output is_near, input ready);
    modport sink   (input valid, input distance_cm, input is_near, output ready);
endinterface

// ===== sv/ultrasonic_range_moving_average.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range moving average
// Converts echo times to centimetres and averages them over a sample ring.
// ----------------------------------------------------------------------------
// i_echo takes one echo high time per item; o_dist returns one distance and a
// near flag per item, in order. Both use valid/ready; an item moves on a clock
// edge where both are high. The write port (i_cfg_we, i_cfg_idx, i_cfg_data)
// sets filter enable, window size and the near threshold; write it only while
// no item is in flight. Writing the window size empties the sample ring.
// The conversion is one multiply by a fixed-point reciprocal of 10000/172.
// Unfiltered, an item passes the multiply state and then the output state.
// With filtering on, the ring is read and rewritten in the read and sum
// states, and the sum is divided by the window size on a restoring divider
// at one quotient bit per cycle. The block takes a new item only once the
// last one has been loaded into the output register.
// A finished result sits in an output register; a new item is accepted while
// it waits. If the receiver stalls, the next item stops at the end of its work
// until the register frees. Reset (synchronous, active low) empties the ring,
// clears the sum and loads filter on, window 5, threshold 0.
// ----------------------------------------------------------------------------
module ultrasonic_range_moving_average
    import urma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    urma_echo_if.sink             i_echo,
    urma_dist_if.source           o_dist,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam int CNT_W = $clog2(DIST_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIST_W - 1);

    // Configuration registers
    logic              r_filt_en;
    logic [WIN_W-1:0]  r_win;
    logic [DIST_W-1:0] r_thresh;

    // Ring bookkeeping
    logic [WINDOW_MAX-1:0] r_vld;
    logic [SUM_W-1:0]      r_sum;
    logic [SLOT_W-1:0]     r_slot;

    // Sequencer and datapath registers
    logic [2:0]        r_state;
    logic [DUR_W-1:0]  r_us;
    logic [DVSR_W-1:0] r_rem;
    logic [DIST_W-1:0] r_quo;
    logic [DVSR_W-1:0] r_dvsr;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIST_W-1:0] r_dist;
    logic [DIST_W-1:0] r_res;

    // Output register
    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_near;

    // Sample ring memory with registered read data
    logic [DIST_W-1:0] mem [WINDOW_MAX];
    logic [DIST_W-1:0] r_rd_data;
    logic              mem_we;

    logic              win_clear;
    logic [WIN_W-1:0]  cfg_win;
    logic              in_fire;
    logic              out_fire;
    logic              out_load;

    logic [MUL_W-1:0]  prod;
    logic [DIST_W-1:0] cm_val;
    logic [DVSR_W:0]   div_trial;
    logic              div_ge;
    logic [DVSR_W:0]   div_diff;
    logic [SLOT_W-1:0] sel_slot;
    logic [WIN_W-1:0]  slot_inc;
    logic [SLOT_W-1:0] next_slot;
    logic [DIST_W-1:0] old_sample;
    logic [SUM_W-1:0]  n_sum;

    // Handshakes
    assign in_fire        = i_echo.valid && i_echo.ready;
    assign out_fire       = o_dist.valid && o_dist.ready;
    assign i_echo.ready   = (r_state == S_IDLE);
    assign out_load       = (r_state == S_OUT) && (!r_out_valid || o_dist.ready);
    assign o_dist.valid       = r_out_valid;
    assign o_dist.distance_cm = r_out_dist;
    assign o_dist.is_near     = r_out_near;

    // Window size write: clamp to 1..WINDOW_MAX and empty the ring
    assign win_clear = i_cfg_we && (i_cfg_idx == CFG_WINDOW);
    always_comb begin
        cfg_win = i_cfg_data[WIN_W-1:0];
        if (cfg_win == '0) begin
            cfg_win = WIN_MIN;
        end else if (cfg_win > WIN_LIMIT) begin
            cfg_win = WIN_LIMIT;
        end
    end

    // Duration to centimetres by multiplying with the scaled reciprocal
    assign prod   = MUL_W'(r_us) * MUL_W'(CM_RECIP);
    assign cm_val = DIST_W'(prod >> CM_SHIFT);

    // One restoring divide step: shift in the next dividend bit, try the divisor
    assign div_trial = {r_rem, r_quo[DIST_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_dvsr});
    assign div_diff  = div_trial - {1'b0, r_dvsr};

    // Ring slot for this item and the slot after it
    assign sel_slot  = ({1'b0, r_slot} >= r_win) ? '0 : r_slot;
    assign slot_inc  = {1'b0, sel_slot} + WIN_W'(1);
    assign next_slot = (slot_inc >= r_win) ? '0 : slot_inc[SLOT_W-1:0];

    // Replace the oldest sample in the running sum; an unwritten slot reads as zero
    assign old_sample = r_vld[sel_slot] ? r_rd_data : '0;
    assign n_sum      = r_sum - SUM_W'(old_sample) + SUM_W'(r_dist);
    assign mem_we     = (r_state == S_SUM);

    // Sample ring memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[sel_slot] <= r_dist;
        end
        r_rd_data <= mem[sel_slot];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_en <= 1'b1;
            r_win     <= WIN_RESET;
            r_thresh  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILTER_EN: r_filt_en <= i_cfg_data[0];
                CFG_WINDOW:    r_win     <= cfg_win;
                CFG_THRESHOLD: r_thresh  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ring valid bits, running sum and write slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || win_clear) begin
            r_vld  <= '0;
            r_sum  <= '0;
            r_slot <= '0;
        end else if (mem_we) begin
            r_vld[sel_slot] <= 1'b1;
            r_sum           <= n_sum;
            r_slot          <= next_slot;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= r_filt_en ? S_RD : S_OUT;
                S_DIV: begin
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_OUT;
                    end
                end
                S_RD:  r_state <= S_SUM;
                S_SUM: r_state <= S_DIV;
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: convert, load the divider, iterate, collect the quotient
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_us <= i_echo.echo_duration_us;
                end
            end
            S_MUL: begin
                r_dist <= cm_val;
                r_res  <= cm_val;
            end
            S_DIV: begin
                r_rem <= div_ge ? div_diff[DVSR_W-1:0] : div_trial[DVSR_W-1:0];
                r_quo <= {r_quo[DIST_W-2:0], div_ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    r_res <= {r_quo[DIST_W-2:0], div_ge};
                end
            end
            S_SUM: begin
                r_rem  <= DVSR_W'(n_sum[SUM_W-1:DIST_W]);
                r_quo  <= n_sum[DIST_W-1:0];
                r_dvsr <= DVSR_W'(r_win);
                r_cnt  <= '0;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dist <= r_res;
            r_out_near <= (r_res <= r_thresh);
        end
    end

endmodule

// ===== bench/ultrasonic_range_moving_average_test.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range moving average testbench
// Sends echo times into the range filter and checks every returned distance
// and near flag against an in-bench model of the conversion, the sample ring
// and the threshold compare. Directed cases cover the field extremes, window
// clamping, pass-through and threshold edges; random traffic follows under
// three patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module ultrasonic_range_moving_average_test
    import urma_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    // One returned distance item
    typedef struct packed {
        logic [DIST_W-1:0] distance_cm;
        logic              is_near;
    } t_range;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    urma_echo_if echo_ch ();
    urma_dist_if dist_ch ();

    ultrasonic_range_moving_average dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_echo     (echo_ch),
        .o_dist     (dist_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Model of the filter settings and the averaging store
    logic              avg_on;
    logic [WIN_W-1:0]  avg_window;
    logic [DIST_W-1:0] near_limit;
    logic [DIST_W-1:0] recent_cm [WINDOW_MAX];
    logic [SUM_W-1:0]  ring_sum;
    int                next_slot;

    t_range expected_ranges [$];

    int gap_pct;
    int stall_pct;
    int items_sent;
    int ranges_checked;
    int reg_writes;
    int mismatches;
    int quiet_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Empty the modeled ring, as reset and a window write do.
    task automatic clear_ring_model();
        for (int i = 0; i < WINDOW_MAX; i++) begin
            recent_cm[i] = '0;
        end
        ring_sum  = '0;
        next_slot = 0;
    endtask

    // Round trip time in microseconds to one-way distance in whole centimetres.
    function automatic logic [DIST_W-1:0] echo_to_cm(input logic [DUR_W-1:0] us);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(us) * PROD_W'(CM_SCALE);
        return DIST_W'(prod / PROD_W'(CM_DIV));
    endfunction

    // Work out the distance item that one echo item causes.
    task automatic predict_range(input logic [DUR_W-1:0] us);
        logic [DIST_W-1:0] cm;
        logic [DIST_W-1:0] range_cm;
        int                slot;
        t_range            want;
        cm = echo_to_cm(us);
        if (avg_on) begin
            slot = next_slot;
            if (slot >= avg_window) slot = 0;
            ring_sum        = SUM_W'(ring_sum - recent_cm[slot]);
            recent_cm[slot] = cm;
            ring_sum        = SUM_W'(ring_sum + cm);
            slot++;
            if (slot >= avg_window) slot = 0;
            next_slot = slot;
            range_cm = DIST_W'(ring_sum / avg_window);
        end else begin
            range_cm = cm;
        end
        want.distance_cm = range_cm;
        want.is_near     = (range_cm <= near_limit);
        expected_ranges.push_back(want);
    endtask

    // Write one register; the enable stays high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        logic [WIN_W-1:0] win;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        reg_writes++;
        case (idx)
            CFG_FILTER_EN: begin
                avg_on = data[0];
            end
            CFG_WINDOW: begin
                win = data[WIN_W-1:0];
                if (win == '0) win = WIN_MIN;
                if (win > WIN_LIMIT) win = WIN_LIMIT;
                avg_window = win;
                clear_ring_model();
            end
            CFG_THRESHOLD: begin
                near_limit = data[DIST_W-1:0];
            end
            default: ;
        endcase
    endtask

    // Write a chosen subset of the registers in index order.
    task automatic write_regs(input bit set_en, input bit set_win, input bit set_thr,
                              input logic [CFG_DATA_W-1:0] en_data,
                              input logic [CFG_DATA_W-1:0] win_data,
                              input logic [CFG_DATA_W-1:0] thr_data);
        if (set_en) write_reg(CFG_FILTER_EN, en_data);
        if (set_win) write_reg(CFG_WINDOW, win_data);
        if (set_thr) write_reg(CFG_THRESHOLD, thr_data);
        if (set_en || set_win || set_thr) i_cfg_we <= 1'b0;
    endtask

    // Offer one echo item after a random gap and wait until it is taken.
    task automatic send_echo(input logic [DUR_W-1:0] us);
        while ($urandom_range(99) < gap_pct) begin
            if (echo_ch.valid) echo_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        echo_ch.valid            <= 1'b1;
        echo_ch.echo_duration_us <= us;
        do @(posedge i_clk); while (!echo_ch.ready);
        predict_range(us);
        items_sent++;
    endtask

    // Stop offering items and wait for every expected distance to return.
    task automatic drain_ranges();
        if (echo_ch.valid) echo_ch.valid <= 1'b0;
        while (expected_ranges.size() != 0) @(posedge i_clk);
    endtask

    // Echo time mix: full field, sensor range, short ranges, timeouts, top end.
    function automatic logic [DUR_W-1:0] random_echo();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return DUR_W'($urandom);
        else if (pick < 70) return DUR_W'($urandom_range(1000000));
        else if (pick < 85) return DUR_W'($urandom_range(2000));
        else if (pick < 93) return '0;
        else return DUR_W'($urandom_range(1040000, 1048575));
    endfunction

    // Default settings after reset: filter on, window of five, threshold zero.
    task automatic test_after_reset();
        send_echo(20'd0);
        send_echo(20'd58);
        send_echo(20'd59);
        send_echo(20'd290);
        send_echo(20'd1000000);
        send_echo(20'hFFFFF);
        drain_ranges();
    endtask

    // Window of zero acts as one; oversized windows saturate at the ring depth.
    task automatic test_window_limits();
        write_regs(1'b0, 1'b1, 1'b1, '0, 15'd0, 15'd17200);
        send_echo(20'hFFFFF);
        send_echo(20'd100000);
        drain_ranges();
        write_regs(1'b0, 1'b1, 1'b0, '0, 15'h7FFF, '0);
        send_echo(20'hFFFFF);
        send_echo(20'hFFFFF);
        send_echo(20'd12345);
        drain_ranges();
        write_regs(1'b0, 1'b1, 1'b0, '0, 15'h5550, '0);
        send_echo(20'd999999);
        send_echo(20'd1);
        drain_ranges();
    endtask

    // Filter off passes raw distances; turning it back on keeps the ring.
    task automatic test_pass_through();
        write_regs(1'b1, 1'b0, 1'b1, 15'h7FFE, '0, 15'h7FFF);
        send_echo(20'd0);
        send_echo(20'hFFFFF);
        send_echo(20'd1000000);
        drain_ranges();
        write_regs(1'b1, 1'b0, 1'b0, 15'h0001, '0, '0);
        send_echo(20'd5000);
        send_echo(20'd0);
        drain_ranges();
    endtask

    // Distances exactly at and one above the threshold.
    task automatic test_near_threshold();
        write_regs(1'b1, 1'b0, 1'b1, 15'h0000, '0, 15'd17200);
        send_echo(20'd1000000);
        send_echo(20'd1000059);
        drain_ranges();
        write_regs(1'b0, 1'b0, 1'b1, '0, '0, 15'd0);
        send_echo(20'd58);
        send_echo(20'd59);
        drain_ranges();
    endtask

    // Bursts of random echo items with random settings written between bursts.
    task automatic test_random_traffic(input int send_gap, input int recv_stall,
                                       input int count);
        int                    sent;
        int                    burst;
        logic [CFG_DATA_W-1:0] en_data;
        logic [CFG_DATA_W-1:0] win_data;
        logic [CFG_DATA_W-1:0] thr_data;
        gap_pct   = send_gap;
        stall_pct = recv_stall;
        sent      = 0;
        while (sent < count) begin
            drain_ranges();
            en_data    = CFG_DATA_W'($urandom);
            en_data[0] = ($urandom_range(3) != 0);
            case ($urandom_range(5))
                0: win_data = '0;
                1: win_data = CFG_DATA_W'(WINDOW_MAX);
                2: win_data = CFG_DATA_W'(1);
                default: win_data = CFG_DATA_W'($urandom);
            endcase
            case ($urandom_range(4))
                0: thr_data = '0;
                1: thr_data = '1;
                2: thr_data = CFG_DATA_W'($urandom);
                default: thr_data = CFG_DATA_W'($urandom_range(18035));
            endcase
            write_regs(1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), en_data, win_data, thr_data);
            burst = $urandom_range(20, 60);
            repeat (burst) send_echo(random_echo());
            sent += burst;
        end
    endtask

    // Compare one returned distance item with the oldest expectation.
    task automatic check_range();
        t_range want;
        if (expected_ranges.size() == 0) begin
            $error("distance item with none expected: distance_cm %0d is_near %0d",
                   dist_ch.distance_cm, dist_ch.is_near);
            mismatches++;
        end else begin
            want = expected_ranges.pop_front();
            if (dist_ch.distance_cm !== want.distance_cm) begin
                $error("distance_cm: expected %0d, actual %0d",
                       want.distance_cm, dist_ch.distance_cm);
                mismatches++;
            end
            if (dist_ch.is_near !== want.is_near) begin
                $error("is_near: expected %0d, actual %0d", want.is_near, dist_ch.is_near);
                mismatches++;
            end
        end
        ranges_checked++;
    endtask

    // Receiver: take distance items and stall at random.
    initial begin
        dist_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && dist_ch.valid && dist_ch.ready) check_range();
            dist_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run when no item moves on either channel for too long.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((echo_ch.valid && echo_ch.ready) || (dist_ch.valid && dist_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Test sequence
    initial begin
        i_rst_n                  <= 1'b0;
        i_cfg_we                 <= 1'b0;
        i_cfg_idx                <= CFG_FILTER_EN;
        i_cfg_data               <= '0;
        echo_ch.valid            <= 1'b0;
        echo_ch.echo_duration_us <= '0;
        avg_on         = 1'b1;
        avg_window     = WIN_RESET;
        near_limit     = '0;
        items_sent     = 0;
        ranges_checked = 0;
        reg_writes     = 0;
        mismatches     = 0;
        gap_pct        = 22;
        stall_pct      = 81;
        clear_ring_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_window_limits();
        test_pass_through();
        test_near_threshold();
        test_random_traffic(22, 81, 470);
        test_random_traffic(81, 22, 470);
        test_random_traffic(0, 0, 460);

        drain_ranges();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d distance items for %0d echo items across %0d register writes.",
                 ranges_checked, items_sent, reg_writes);
        $display("Covered reset defaults, window clamping, pass-through, threshold edges"
                 , " and random traffic under three idle patterns.");
        if (mismatches == 0 && expected_ranges.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
